/* src/twcc_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle winding check package
// Shared payload types, register indexes, verdict codes and the control
// interface between the controller and the datapath.
// ----------------------------------------------------------------------------
package twcc_pkg;

    // Input vertex: Q8.8 position, Q1.14 normal and the end-of-mesh mark.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic               last_vertex;
    } vertex_t;

    // Result delivered on the mesh's last vertex.
    typedef struct packed {
        logic [1:0]  verdict;
        logic [20:0] inverted_count;
        logic [20:0] counted_total;
    } result_t;

    // Configuration port widths and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_AREA_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_NORMAL_LIMIT = 2'd1;
    localparam int NORMAL_LIMIT_W = 37;

    // Verdict codes.
    localparam logic [1:0] VERDICT_CLEAN      = 2'd0;
    localparam logic [1:0] VERDICT_FLIPPED    = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE_OUT = 2'd2;
    localparam logic [1:0] VERDICT_EMPTY      = 2'd3;

    // Tally field width and its largest value.
    localparam int TALLY_W = 21;
    localparam int unsigned TALLY_FIELD_MAX = 2097151;

    // Multiply sequence: steps 0 to STEP_LAST_ISSUE issue a product, the
    // drain step only accumulates the final one.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LAST_ISSUE = 4'd14;
    localparam logic [STEP_W-1:0] STEP_DRAIN      = 4'd15;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_vertex;
        logic              hold_sel;
        logic              load_edges;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              decide;
        logic              emit;
    } twcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } twcc_stat_t;

    // Sign extension helpers for the edge and normal-sum adders.
    function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
        sx17 = $signed({v[15], v});
    endfunction

    function automatic logic signed [17:0] sx18(input logic signed [15:0] v);
        sx18 = $signed({{2{v[15]}}, v});
    endfunction

endpackage

/* src/twcc_ctrl.sv */
// ----------------------------------------------------------------------------
// Triangle winding check controller
// Tracks the vertex position within the open triangle and sequences the
// shared multiplier, the decision and the result hand-off.
// ----------------------------------------------------------------------------
module twcc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_last,
    input  twcc_pkg::twcc_stat_t   stat,
    output twcc_pkg::twcc_cmd_t    cmd
);
    import twcc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam logic [1:0] PHASE_CLOSE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_reg, last_next;
    logic              s_accept;

    assign s_accept = s_valid && s_ready;

    // Next-state and command logic.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_accept) begin
                    if (phase_reg == PHASE_CLOSE) begin
                        cmd.load_edges = 1'b1;
                        phase_next     = 2'd0;
                        step_next      = '0;
                        last_next      = s_last;
                        state_next     = ST_CALC;
                    end else begin
                        cmd.load_vertex = 1'b1;
                        cmd.hold_sel    = phase_reg[0];
                        if (s_last) begin
                            phase_next = 2'd0;
                            state_next = ST_EMIT;
                        end else begin
                            phase_next = phase_reg + 2'd1;
                        end
                    end
                end
            end
            ST_CALC: begin
                cmd.issue = (step_reg <= STEP_LAST_ISSUE);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_DRAIN) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 2'd0;
            step_reg  <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
        end
    end

    // A closing vertex always starts the multiply sequence from step zero.
    a_close_starts_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PHASE_CLOSE) |=> (state_reg == ST_CALC && step_reg == '0))
        else $error("closing vertex did not start the multiply sequence");

    // The drain step hands over to the decision.
    a_drain_to_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && step_reg == STEP_DRAIN) |=> (state_reg == ST_DECIDE))
        else $error("multiply sequence did not end in the decision");

    // Outside idle no triangle is open.
    a_phase_clear_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (phase_reg == 2'd0))
        else $error("vertex phase not cleared while busy");

endmodule

/* src/twcc_datapath.sv */
// ----------------------------------------------------------------------------
// Triangle winding check datapath
// Holds the open triangle's first two vertices, forms edges and the normal
// sum, runs the cross, square and dot products through one shared multiplier,
// keeps the saturating tallies and the output register.
// ----------------------------------------------------------------------------
module twcc_datapath #(
    parameter int MAX_TRIANGLES = 1048576
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  twcc_pkg::twcc_cmd_t                  cmd,
    output twcc_pkg::twcc_stat_t                 stat,
    input  twcc_pkg::vertex_t                    s_data,
    input  logic                                 cfg_valid,
    input  logic [twcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [twcc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output twcc_pkg::result_t                    m_data
);
    import twcc_pkg::*;

    localparam int unsigned CAP_INT =
        (MAX_TRIANGLES > TALLY_FIELD_MAX) ? TALLY_FIELD_MAX : MAX_TRIANGLES;
    localparam logic [TALLY_W-1:0] TALLY_CAP = TALLY_W'(CAP_INT);

    // Multiply sequence steps.
    localparam logic [STEP_W-1:0] STEP_C0_LOAD  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_C0_SUB   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_C1_LOAD  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_C1_SUB   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_C2_LOAD  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_C2_SUB   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CSQ_LOAD = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CSQ_ADD1 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CSQ_ADD2 = 4'd8;
    localparam logic [STEP_W-1:0] STEP_NSQ_LOAD = 4'd9;
    localparam logic [STEP_W-1:0] STEP_NSQ_ADD1 = 4'd10;
    localparam logic [STEP_W-1:0] STEP_NSQ_ADD2 = 4'd11;
    localparam logic [STEP_W-1:0] STEP_DOT_LOAD = 4'd12;
    localparam logic [STEP_W-1:0] STEP_DOT_ADD1 = 4'd13;
    localparam logic [STEP_W-1:0] STEP_DOT_ADD2 = 4'd14;

    // Configuration registers.
    logic [CFG_DATA_W-1:0]     area_limit_reg;
    logic [NORMAL_LIMIT_W-1:0] normal_limit_reg;

    // Triangle working registers.
    vertex_t              held_reg [2];
    logic signed [16:0]   e1_reg [3];
    logic signed [16:0]   e2_reg [3];
    logic signed [17:0]   n_reg [3];
    logic signed [34:0]   c_reg [3];
    logic [71:0]          csq_reg;
    logic [36:0]          nsq_reg;
    logic signed [55:0]   dot_reg;

    // Shared multiplier.
    logic signed [35:0]   op_a, op_b;
    logic signed [71:0]   prod_reg;
    logic                 acc_valid_reg;
    logic [STEP_W-1:0]    acc_step_reg;

    // Tallies and output.
    logic [TALLY_W-1:0]   inv_reg, tot_reg;
    logic                 m_valid_reg;
    result_t              m_data_reg;

    logic                 degenerate, zero_normal, counted;
    logic [1:0]           verdict;
    logic [25:0]          inv_x20;

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_limit_reg   <= '0;
            normal_limit_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_IDX_AREA_LIMIT) begin
                area_limit_reg <= cfg_data;
            end
            if (cfg_index == CFG_IDX_NORMAL_LIMIT) begin
                normal_limit_reg <= cfg_data[NORMAL_LIMIT_W-1:0];
            end
        end
    end

    // Vertex hold and edge / normal-sum formation on the closing vertex.
    always_ff @(posedge aclk) begin
        if (cmd.load_vertex) begin
            held_reg[cmd.hold_sel] <= s_data;
        end
        if (cmd.load_edges) begin
            e1_reg[0] <= sx17(held_reg[1].pos_x) - sx17(held_reg[0].pos_x);
            e1_reg[1] <= sx17(held_reg[1].pos_y) - sx17(held_reg[0].pos_y);
            e1_reg[2] <= sx17(held_reg[1].pos_z) - sx17(held_reg[0].pos_z);
            e2_reg[0] <= sx17(s_data.pos_x) - sx17(held_reg[0].pos_x);
            e2_reg[1] <= sx17(s_data.pos_y) - sx17(held_reg[0].pos_y);
            e2_reg[2] <= sx17(s_data.pos_z) - sx17(held_reg[0].pos_z);
            n_reg[0]  <= sx18(held_reg[0].nrm_x) + sx18(held_reg[1].nrm_x)
                         + sx18(s_data.nrm_x);
            n_reg[1]  <= sx18(held_reg[0].nrm_y) + sx18(held_reg[1].nrm_y)
                         + sx18(s_data.nrm_y);
            n_reg[2]  <= sx18(held_reg[0].nrm_z) + sx18(held_reg[1].nrm_z)
                         + sx18(s_data.nrm_z);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.step)
            STEP_C0_LOAD:  begin op_a = 36'(e1_reg[1]); op_b = 36'(e2_reg[2]); end
            STEP_C0_SUB:   begin op_a = 36'(e1_reg[2]); op_b = 36'(e2_reg[1]); end
            STEP_C1_LOAD:  begin op_a = 36'(e1_reg[2]); op_b = 36'(e2_reg[0]); end
            STEP_C1_SUB:   begin op_a = 36'(e1_reg[0]); op_b = 36'(e2_reg[2]); end
            STEP_C2_LOAD:  begin op_a = 36'(e1_reg[0]); op_b = 36'(e2_reg[1]); end
            STEP_C2_SUB:   begin op_a = 36'(e1_reg[1]); op_b = 36'(e2_reg[0]); end
            STEP_CSQ_LOAD: begin op_a = 36'(c_reg[0]);  op_b = 36'(c_reg[0]);  end
            STEP_CSQ_ADD1: begin op_a = 36'(c_reg[1]);  op_b = 36'(c_reg[1]);  end
            STEP_CSQ_ADD2: begin op_a = 36'(c_reg[2]);  op_b = 36'(c_reg[2]);  end
            STEP_NSQ_LOAD: begin op_a = 36'(n_reg[0]);  op_b = 36'(n_reg[0]);  end
            STEP_NSQ_ADD1: begin op_a = 36'(n_reg[1]);  op_b = 36'(n_reg[1]);  end
            STEP_NSQ_ADD2: begin op_a = 36'(n_reg[2]);  op_b = 36'(n_reg[2]);  end
            STEP_DOT_LOAD: begin op_a = 36'(c_reg[0]);  op_b = 36'(n_reg[0]);  end
            STEP_DOT_ADD1: begin op_a = 36'(c_reg[1]);  op_b = 36'(n_reg[1]);  end
            STEP_DOT_ADD2: begin op_a = 36'(c_reg[2]);  op_b = 36'(n_reg[2]);  end
            default:       begin op_a = '0;             op_b = '0;             end
        endcase
    end

    // Product register, tagged with the step that produced it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
        end else begin
            acc_valid_reg <= cmd.issue;
        end
        if (cmd.issue) begin
            prod_reg     <= op_a * op_b;
            acc_step_reg <= cmd.step;
        end
    end

    // Accumulation of the registered product in the cycle after issue.
    always_ff @(posedge aclk) begin
        if (acc_valid_reg) begin
            unique case (acc_step_reg)
                STEP_C0_LOAD:  c_reg[0] <= $signed(prod_reg[34:0]);
                STEP_C0_SUB:   c_reg[0] <= c_reg[0] - $signed(prod_reg[34:0]);
                STEP_C1_LOAD:  c_reg[1] <= $signed(prod_reg[34:0]);
                STEP_C1_SUB:   c_reg[1] <= c_reg[1] - $signed(prod_reg[34:0]);
                STEP_C2_LOAD:  c_reg[2] <= $signed(prod_reg[34:0]);
                STEP_C2_SUB:   c_reg[2] <= c_reg[2] - $signed(prod_reg[34:0]);
                STEP_CSQ_LOAD: csq_reg  <= prod_reg;
                STEP_CSQ_ADD1,
                STEP_CSQ_ADD2: csq_reg  <= csq_reg + prod_reg;
                STEP_NSQ_LOAD: nsq_reg  <= prod_reg[36:0];
                STEP_NSQ_ADD1,
                STEP_NSQ_ADD2: nsq_reg  <= nsq_reg + prod_reg[36:0];
                STEP_DOT_LOAD: dot_reg  <= $signed(prod_reg[55:0]);
                STEP_DOT_ADD1,
                STEP_DOT_ADD2: dot_reg  <= dot_reg + $signed(prod_reg[55:0]);
                default: begin
                end
            endcase
        end
    end

    // Triangle classification against the configured limits.
    assign degenerate  = (csq_reg <= {8'd0, area_limit_reg});
    assign zero_normal = (nsq_reg <= normal_limit_reg);
    assign counted     = !degenerate && !zero_normal && (dot_reg != '0);

    // Verdict from the tallies.
    assign inv_x20 = 26'(inv_reg) * 26'd20;
    always_comb begin
        priority if (tot_reg == '0) begin
            verdict = VERDICT_EMPTY;
        end else if ({inv_reg, 1'b0} > {1'b0, tot_reg}) begin
            verdict = VERDICT_INSIDE_OUT;
        end else if (inv_x20 > 26'(tot_reg)) begin
            verdict = VERDICT_FLIPPED;
        end else begin
            verdict = VERDICT_CLEAN;
        end
    end

    // Saturating tallies, cleared when a result is handed off.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg <= '0;
            tot_reg <= '0;
        end else if (cmd.emit) begin
            inv_reg <= '0;
            tot_reg <= '0;
        end else if (cmd.decide && counted) begin
            if (tot_reg < TALLY_CAP) begin
                tot_reg <= tot_reg + 1'b1;
            end
            if (dot_reg[55] && inv_reg < TALLY_CAP) begin
                inv_reg <= inv_reg + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_data_reg.verdict        <= verdict;
            m_data_reg.inverted_count <= inv_reg;
            m_data_reg.counted_total  <= tot_reg;
        end
    end

    // Every inverted triangle is also in the total.
    a_inv_within_total: assert property (@(posedge aclk) disable iff (!aresetn)
        inv_reg <= tot_reg)
        else $error("inverted tally exceeds total tally");

    // Handing off a result starts a fresh mesh.
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (inv_reg == '0 && tot_reg == '0))
        else $error("tallies not cleared after a result");

    // The empty verdict goes with a zero total and only with it.
    a_empty_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.verdict == VERDICT_EMPTY)
                         == (m_data_reg.counted_total == '0)))
        else $error("empty verdict does not match the total");

endmodule

/* src/triangle_winding_consistency_check_core.sv */
// ----------------------------------------------------------------------------
// Triangle winding consistency check core
// Checks that each triangle's winding agrees with the sum of its vertex
// normals and reports per-mesh counts and a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices enter on the s_ channel (s_valid / s_ready / s_data) in triangle
//   order. Every third vertex closes a triangle. A vertex with last_vertex set
//   ends the mesh: one result transaction leaves on the m_ channel with the
//   verdict and the inverted and counted totals, and the tallies clear. An
//   incomplete trailing triangle is dropped. The cfg_ channel writes the two
//   limits (index 0 area, index 1 normal); it is always ready, and the user
//   must use it only while the core is idle, which the core does not enforce.
// Sequence:
//   A vertex that does not close a triangle is taken while idle. A closing
//   vertex loads the edges and normal sum; 15 products then go one per cycle
//   through a single shared 36x36 multiplier, the drain step accumulates the
//   last product, and the decision follows. A last vertex then enters the
//   emit state, which loads the output register once it is free.
// Reset and stall:
//   Synchronous active-low reset clears the limits, tallies and the open
//   triangle. A result waits in the output register until m_ready; the core
//   keeps taking vertices meanwhile, except while computing a triangle, and
//   stalls only when a second result would need the occupied register.
// ----------------------------------------------------------------------------
module triangle_winding_consistency_check_core #(
    parameter int MAX_TRIANGLES = 1048576
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  twcc_pkg::vertex_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output twcc_pkg::result_t                 m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [twcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [twcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import twcc_pkg::*;

    twcc_cmd_t  cmd;
    twcc_stat_t stat;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer.
    twcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_data.last_vertex),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic, tallies and output register.
    twcc_datapath #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
